### design/sstc_pkg.sv
// Shared constants, register indexes and controller/datapath interface types.
`default_nettype none

package sstc_pkg;

    localparam int SIZE_W          = 6;
    localparam int THR_W           = 40;
    localparam int COUNT_W         = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int MAX_VALUES_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GROUP1    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP2    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRUNING   = 2'd3;

    typedef struct packed {
        logic load;
        logic init;
        logic eval;
        logic leaf_step;
        logic descend;
        logic pop;
        logic restore;
        logic emit_count;
        logic emit_zero;
        logic emit_err;
    } sstc_cmd_t;

    typedef struct packed {
        logic load_err;
        logic load_empty;
        logic load_last;
        logic n1_zero;
        logic out_of_range;
        logic lv_one;
        logic is_leaf;
        logic leaf_hit;
        logic cut;
    } sstc_status_t;

endpackage

`default_nettype wire

### design/sstc_ctrl.sv
// Controller state machine for load and depth-first subset search.
`default_nettype none

module sstc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire sstc_pkg::sstc_status_t status,
    output sstc_pkg::sstc_cmd_t        cmd,
    output logic                       busy
);
    import sstc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_DECIDE,
        S_POP
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;
    logic   accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (status.load_err)
                    begin
                        cmd.emit_err = 1'b1;
                    end
                    else if (status.load_empty)
                    begin
                        cmd.emit_zero = 1'b1;
                    end
                    else if (status.load_last)
                    begin
                        if (status.n1_zero)
                        begin
                            cmd.emit_zero = 1'b1;
                        end
                        else
                        begin
                            cmd.init   = 1'b1;
                            state_next = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                if (status.out_of_range)
                begin
                    if (status.lv_one)
                    begin
                        cmd.emit_count = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.pop    = 1'b1;
                        state_next = S_POP;
                    end
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.is_leaf)
                begin
                    cmd.leaf_step = 1'b1;
                    state_next    = S_FETCH;
                end
                else if (status.cut)
                begin
                    if (status.lv_one)
                    begin
                        cmd.emit_count = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.pop    = 1'b1;
                        state_next = S_POP;
                    end
                end
                else
                begin
                    cmd.descend = 1'b1;
                    state_next  = S_FETCH;
                end
            end
            S_POP:
            begin
                cmd.restore = 1'b1;
                state_next  = S_FETCH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

endmodule

`default_nettype wire

### design/sstc_datapath.sv
// Datapath: configuration, value store, search stack, sums and result registers.
`default_nettype none

module sstc_datapath #(
    parameter int MAX_VALUES  = sstc_pkg::MAX_VALUES_DEF,
    parameter int VALUE_WIDTH = sstc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [sstc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [sstc_pkg::THR_W-1:0]           cfg_data,
    input  wire logic signed [VALUE_WIDTH-1:0]        sample_value,
    input  wire sstc_pkg::sstc_cmd_t                  cmd,
    output sstc_pkg::sstc_status_t                    status,
    output logic [sstc_pkg::COUNT_W-1:0]              match_count,
    output logic                                      size_error,
    output logic                                      done
);
    import sstc_pkg::*;

    localparam int IDX_W  = $clog2(MAX_VALUES + 1);
    localparam int ADDR_W = $clog2(MAX_VALUES);
    localparam int CMP_W  = SIZE_W + 1;
    localparam int SUM_W  = (VALUE_WIDTH + 8 > THR_W + 1) ? VALUE_WIDTH + 8 : THR_W + 1;
    localparam int PROD_W = VALUE_WIDTH + SIZE_W + 1;
    localparam int ENT_W  = IDX_W + SUM_W;

    // configuration
    logic [SIZE_W-1:0]       group1_reg, group2_reg;
    logic signed [THR_W-1:0] thr_reg;
    logic                    prune_reg;

    // stores
    logic signed [VALUE_WIDTH-1:0] store_mem [MAX_VALUES];
    logic [ENT_W-1:0]              stack_mem [MAX_VALUES];

    // search state
    logic [IDX_W-1:0]              lc_reg;
    logic [IDX_W-1:0]              lv_reg;
    logic [IDX_W-1:0]              cur_reg;
    logic signed [SUM_W-1:0]       psum_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SUM_W-1:0]       prod_reg;
    logic [COUNT_W-1:0]            count_reg;
    logic signed [VALUE_WIDTH-1:0] v0_reg, v1_reg;
    logic [ENT_W-1:0]              stack_rd_reg;

    // results
    logic [COUNT_W-1:0] match_count_reg;
    logic               size_error_reg;
    logic               done_reg;

    logic [CMP_W-1:0]        total, n1_c, n2_c, lv_c, cur_c, lc_inc;
    logic [SIZE_W-1:0]       picks_left;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0] thr_ext, bound;
    logic [ADDR_W-1:0]       rd0_addr, rd1_addr, stk_wr_addr, stk_rd_addr, st_wr_addr;

    assign n1_c   = CMP_W'(group1_reg);
    assign n2_c   = CMP_W'(group2_reg);
    assign total  = n1_c + n2_c;
    assign lv_c   = CMP_W'(lv_reg);
    assign cur_c  = CMP_W'(cur_reg);
    assign lc_inc = CMP_W'(lc_reg) + CMP_W'(1);

    assign picks_left = SIZE_W'(n1_c - lv_c);
    assign prod       = $signed({1'b0, picks_left}) * v1_reg;
    assign thr_ext    = SUM_W'(thr_reg);
    assign bound      = sum_reg + prod_reg;

    assign rd0_addr    = cur_reg[ADDR_W-1:0];
    assign rd1_addr    = ADDR_W'(cur_reg + IDX_W'(1));
    assign stk_wr_addr = ADDR_W'(lv_reg - IDX_W'(1));
    assign stk_rd_addr = ADDR_W'(lv_reg - IDX_W'(2));
    assign st_wr_addr  = lc_reg[ADDR_W-1:0];

    always_comb
    begin
        status.load_err     = (total > CMP_W'(MAX_VALUES));
        status.load_empty   = (total == '0);
        status.load_last    = (lc_inc >= total);
        status.n1_zero      = (group1_reg == '0);
        status.out_of_range = (cur_c >= lv_c + n2_c);
        status.lv_one       = (lv_reg == IDX_W'(1));
        status.is_leaf      = (lv_c == n1_c);
        status.leaf_hit     = (sum_reg <= thr_ext);
        status.cut          = prune_reg && (bound > thr_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group1_reg <= SIZE_W'(1);
            group2_reg <= SIZE_W'(1);
            thr_reg    <= '0;
            prune_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GROUP1:    group1_reg <= cfg_data[SIZE_W-1:0];
                CFG_GROUP2:    group2_reg <= cfg_data[SIZE_W-1:0];
                CFG_THRESHOLD: thr_reg    <= $signed(cfg_data);
                CFG_PRUNING:   prune_reg  <= cfg_data[0];
            endcase
        end
    end

    // memories: no reset, reads registered
    always_ff @(posedge clk)
    begin
        if (cmd.load && !status.load_err && !status.load_empty)
        begin
            store_mem[st_wr_addr] <= sample_value;
        end
        if (cmd.descend)
        begin
            stack_mem[stk_wr_addr] <= {cur_reg, psum_reg};
        end
        v0_reg       <= store_mem[rd0_addr];
        v1_reg       <= store_mem[rd1_addr];
        stack_rd_reg <= stack_mem[stk_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg    <= '0;
            lv_reg    <= '0;
            cur_reg   <= '0;
            psum_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit_count || cmd.emit_zero || cmd.emit_err;
            if (cmd.load)
            begin
                if (status.load_err || status.load_empty || status.load_last)
                begin
                    lc_reg <= '0;
                end
                else
                begin
                    lc_reg <= IDX_W'(lc_inc);
                end
            end
            if (cmd.init)
            begin
                lv_reg    <= IDX_W'(1);
                cur_reg   <= '0;
                psum_reg  <= '0;
                count_reg <= '0;
            end
            if (cmd.leaf_step)
            begin
                cur_reg <= cur_reg + IDX_W'(1);
                if (status.leaf_hit)
                begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
            end
            if (cmd.descend)
            begin
                psum_reg <= sum_reg;
                lv_reg   <= lv_reg + IDX_W'(1);
                cur_reg  <= cur_reg + IDX_W'(1);
            end
            if (cmd.pop)
            begin
                lv_reg <= lv_reg - IDX_W'(1);
            end
            if (cmd.restore)
            begin
                cur_reg  <= stack_rd_reg[ENT_W-1 -: IDX_W] + IDX_W'(1);
                psum_reg <= $signed(stack_rd_reg[SUM_W-1:0]);
            end
        end
    end

    // evaluation registers and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            sum_reg  <= psum_reg + SUM_W'(v0_reg);
            prod_reg <= SUM_W'(prod);
        end
        if (cmd.emit_count)
        begin
            match_count_reg <= count_reg;
            size_error_reg  <= 1'b0;
        end
        else if (cmd.emit_zero)
        begin
            match_count_reg <= '0;
            size_error_reg  <= 1'b0;
        end
        else if (cmd.emit_err)
        begin
            match_count_reg <= '0;
            size_error_reg  <= 1'b1;
        end
    end

    assign match_count = match_count_reg;
    assign size_error  = size_error_reg;
    assign done        = done_reg;

endmodule

`default_nettype wire

### design/subset_sum_threshold_counter.sv
// Top level of the subset-sum threshold counter (branch-and-bound permutation test).
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  input    | start, busy             | sample_value
//  result   | done (one-cycle strobe) | match_count, size_error
//  config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// Loading takes one word per cycle; a word is taken when start is high and busy low.
// The last word of a load starts the search: each visited node walks the fetch, evaluate
// and decide states (value store read, sum and bound multiply, decision). A backtrack adds
// a restore state after the stack read; a level found exhausted also spends its fetch.
// Total time is set by the number of nodes walked.
// Result words that need no search appear the cycle after the word that caused them.
// rst_n clears control state and restores register defaults; stores are not cleared.
// The receiver cannot stall: done is high for exactly one cycle per result word.
`default_nettype none

module subset_sum_threshold_counter #(
    parameter int MAX_VALUES  = sstc_pkg::MAX_VALUES_DEF,
    parameter int VALUE_WIDTH = sstc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input words
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [VALUE_WIDTH-1:0]      sample_value,
    // result words
    output logic                                    done,
    output logic [sstc_pkg::COUNT_W-1:0]            match_count,
    output logic                                    size_error,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [sstc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sstc_pkg::THR_W-1:0]         cfg_data
);
    import sstc_pkg::*;

    sstc_cmd_t    cmd;
    sstc_status_t status;
    logic         cfg_we;

    // registers change only between searches; the port closes while busy
    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    sstc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sstc_datapath #(
        .MAX_VALUES  (MAX_VALUES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_value (sample_value),
        .cmd          (cmd),
        .status       (status),
        .match_count  (match_count),
        .size_error   (size_error),
        .done         (done)
    );

    // an error word never carries a count
    a_err_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && size_error |-> match_count == '0)
        else $error("size error word with nonzero count");

    // the search only ends by delivering its count
    a_search_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("search ended without a result word");

    // a result follows either a taken word or a running search
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start))
        else $error("result word without cause");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the subset-sum threshold counter, with an internal predictor.
`timescale 1ns / 100ps

module tb_top;
    import sstc_pkg::*;

    localparam int QUIET_LIMIT   = 200000;  // cycles with no handshake before giving up
    localparam int SETTLE_CYCLES = 8;       // a word's result comes in the cycle after it, search apart
    localparam int RANDOM_WORDS  = 1800;

    localparam logic signed [THR_W-1:0] THR_MIN = {1'b1, {(THR_W-1){1'b0}}};
    localparam logic signed [THR_W-1:0] THR_MAX = {1'b0, {(THR_W-1){1'b1}}};

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               size_err;
    } tally_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [31:0]          sample_value;
    logic                        done;
    logic [COUNT_W-1:0]          match_count;
    logic                        size_error;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [THR_W-1:0]            cfg_data;

    // Register mirror and copy of the value store, as the block should hold them.
    logic [SIZE_W-1:0]           mir_group1;
    logic [SIZE_W-1:0]           mir_group2;
    logic signed [THR_W-1:0]     mir_threshold;
    logic                        mir_pruning;
    logic signed [31:0]          value_copy [MAX_VALUES_DEF];
    int unsigned                 words_loaded;

    tally_t                      pending_tallies [$];
    int unsigned                 words_sent;
    int unsigned                 failures;
    bit                          steady;   // phase with no sender gaps

    subset_sum_threshold_counter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_value (sample_value),
        .done         (done),
        .match_count  (match_count),
        .size_error   (size_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Depth-first walk over index-ascending subsets of exactly group1 values.
    // The bound cut is applied whenever pruning is set, sorted input or not,
    // so unsorted words under pruning give the same (possibly short) count.
    function automatic logic [COUNT_W-1:0] count_qualifying_subsets();
        int unsigned        picks;
        int unsigned        spare;
        int unsigned        lv;
        int unsigned        i;
        int unsigned        pick [MAX_VALUES_DEF];
        longint             acc;
        longint             limit;
        logic [COUNT_W-1:0] hits;
        bit                 retreat;
        picks = mir_group1;
        spare = mir_group2;
        limit = mir_threshold;
        acc   = 0;
        hits  = '0;
        if (picks == 0)
            return hits;
        lv      = 1;
        pick[0] = 0;
        while (lv > 0)
        begin
            i       = pick[lv-1];
            retreat = 1'b0;
            if (i >= lv + spare)
                retreat = 1'b1;
            else
            begin
                acc += value_copy[i];
                if (lv < picks)
                begin
                    // bound: partial sum plus the missing picks at the next value
                    if (mir_pruning && acc + longint'(picks - lv) * value_copy[i+1] > limit)
                    begin
                        acc -= value_copy[i];
                        retreat = 1'b1;
                    end
                    else
                    begin
                        pick[lv] = i + 1;
                        lv++;
                    end
                end
                else
                begin
                    if (acc <= limit)
                        hits++;
                    acc -= value_copy[i];
                    pick[lv-1]++;
                end
            end
            if (retreat)
            begin
                lv--;
                if (lv > 0)
                begin
                    acc -= value_copy[pick[lv-1]];
                    pick[lv-1]++;
                end
            end
        end
        return hits;
    endfunction

    // One accepted word: oversized and empty totals answer at once, otherwise
    // the word is stored and the last one of a load triggers the search.
    function automatic void absorb_word(input logic signed [31:0] v);
        int unsigned total;
        tally_t      t;
        total      = int'(mir_group1) + int'(mir_group2);
        t.count    = '0;
        t.size_err = 1'b0;
        if (total > MAX_VALUES_DEF)
        begin
            words_loaded = 0;
            t.size_err   = 1'b1;
            pending_tallies.push_back(t);
        end
        else if (total == 0)
        begin
            words_loaded = 0;
            pending_tallies.push_back(t);
        end
        else
        begin
            if (words_loaded < MAX_VALUES_DEF)
                value_copy[words_loaded] = v;
            words_loaded++;
            // a size change mid-load can leave the counter past the new total
            if (words_loaded >= total)
            begin
                words_loaded = 0;
                t.count      = count_qualifying_subsets();
                pending_tallies.push_back(t);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // mode 0: full 32-bit range, 1: small spread, 2: tiny spread with many ties
    function automatic logic signed [31:0] draw_word(input int unsigned mode);
        case (mode)
            0:       return $urandom();
            1:       return int'($urandom_range(0, 200)) - 100;
            default: return int'($urandom_range(0, 6)) - 3;
        endcase
    endfunction

    // Threshold near the typical sum of a subset, with the extremes or zero now and then.
    function automatic logic signed [THR_W-1:0] pick_threshold(input int unsigned picks,
                                                              input int unsigned mode);
        int unsigned r;
        longint      base;
        r = $urandom_range(0, 99);
        if (r < 5)
            return THR_MIN;
        if (r < 10)
            return THR_MAX;
        if (r < 13)
            return '0;
        case (mode)
            0:       base = longint'($signed($urandom()));
            1:       base = longint'(int'($urandom_range(0, 200)) - 100);
            default: base = longint'(int'($urandom_range(0, 6)) - 3);
        endcase
        return THR_W'(longint'(picks) * base + longint'(int'($urandom_range(0, 4)) - 2));
    endfunction

    // Start stays high across back-to-back words; it only drops for a gap.
    task automatic send_word(input logic signed [31:0] v);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        sample_value <= v;
        do
            @(posedge clk);
        while (busy);
        absorb_word(v);
        words_sent++;
    endtask

    // Wait until the block has answered everything, then let it go quiet.
    task automatic settle();
        start <= 1'b0;
        while (pending_tallies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_GROUP1:    mir_group1    = data[SIZE_W-1:0];
            CFG_GROUP2:    mir_group2    = data[SIZE_W-1:0];
            CFG_THRESHOLD: mir_threshold = data;
            CFG_PRUNING:   mir_pruning   = data[0];
            default:       ;
        endcase
    endtask

    // Idle the block, then write all four registers; unused upper bits get noise.
    task automatic set_config(input int unsigned n1, input int unsigned n2,
                              input logic signed [THR_W-1:0] thr, input bit prune);
        logic [63:0] noise;
        noise = {$urandom(), $urandom()};
        settle();
        write_reg(CFG_GROUP1, {noise[33:0], SIZE_W'(n1)});
        write_reg(CFG_GROUP2, {noise[63:30], SIZE_W'(n2)});
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_PRUNING, {noise[50:12], prune});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_load(input int unsigned total, input int unsigned mode,
                             input bit ascending);
        logic signed [31:0] batch [MAX_VALUES_DEF];
        logic signed [31:0] key;
        int                 b;
        for (int a = 0; a < total; a++)
            batch[a] = draw_word(mode);
        if (ascending)
        begin
            for (int a = 1; a < total; a++)
            begin
                key = batch[a];
                b   = a;
                while (b > 0 && batch[b-1] > key)
                begin
                    batch[b] = batch[b-1];
                    b--;
                end
                batch[b] = key;
            end
        end
        for (int a = 0; a < total; a++)
            send_word(batch[a]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register defaults: one pick out of two, threshold zero, pruning on.
    task automatic test_reset_defaults();
        send_word(32'sh8000_0000);
        send_word(32'sh7fff_ffff);
    endtask

    // Totals above the store: every word answers with the error flag.
    task automatic test_size_error();
        set_config(63, 63, THR_MAX, 1'b1);
        send_word(32'sd17);
        set_config(33, 32, 40'sd0, 1'b0);
        send_word(-32'sd1);
    endtask

    // Both sizes zero: a zero count per word, no error.
    task automatic test_empty_total();
        set_config(0, 0, 40'sd5, 1'b0);
        send_word(32'sd3);
        send_word(-32'sd3);
    endtask

    // No picks: the load completes normally and counts nothing.
    task automatic test_no_picks();
        set_config(0, 3, THR_MAX, 1'b1);
        send_word(-32'sd4);
        send_word(32'sd0);
        send_word(32'sd9);
    endtask

    // Sizes changed part-way through a load, shrinking once to end it early
    // and once below the number of words already held.
    task automatic test_mid_load_resize();
        set_config(2, 2, THR_MAX, 1'b0);
        send_word(32'sd10);
        send_word(-32'sd20);
        set_config(2, 1, THR_MAX, 1'b0);
        send_word(32'sd30);
        set_config(2, 3, 40'sd15, 1'b0);
        send_word(32'sd7);
        send_word(32'sd8);
        send_word(32'sd9);
        set_config(2, 0, 40'sd15, 1'b0);
        send_word(32'sd100);
    endtask

    // Pruning applied to words that are not ascending.
    task automatic test_unsorted_pruning();
        set_config(2, 2, 40'sd0, 1'b1);
        send_word(32'sd5);
        send_word(-32'sd9);
        send_word(-32'sd1);
        send_word(32'sd3);
    endtask

    // Random phases: mostly small loads, a few of the largest sizes, plus
    // oversized, empty and no-pick settings.
    task automatic test_random_loads();
        int unsigned       kind;
        int unsigned       n1;
        int unsigned       n2;
        int unsigned       total;
        int unsigned       mode;
        int unsigned       loads;
        int unsigned       target;
        bit                prune;
        logic signed [THR_W-1:0] thr;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            kind   = $urandom_range(0, 99);
            mode   = $urandom_range(0, 2);
            prune  = $urandom_range(0, 1);
            loads  = $urandom_range(1, 4);
            steady = ($urandom_range(0, 3) == 0);
            if (kind < 3)
            begin
                loads = 1;
                case ($urandom_range(0, 4))
                    0:       begin n1 = 63; n2 = 1;  end
                    1:       begin n1 = 1;  n2 = 63; end
                    2:       begin n1 = 63; n2 = 0;  end
                    3:       begin n1 = 0;  n2 = 63; end
                    default: begin n1 = 32; n2 = 32; prune = 1'b1; end
                endcase
            end
            else if (kind < 6)
            begin
                n1 = $urandom_range(2, 63);
                n2 = $urandom_range(65 - n1, 63);
            end
            else if (kind < 8)
            begin
                n1 = 0;
                n2 = 0;
            end
            else if (kind < 11)
            begin
                n1 = 0;
                n2 = $urandom_range(1, 10);
            end
            else
            begin
                total = (kind < 21) ? $urandom_range(9, 11) : $urandom_range(2, 8);
                n1    = $urandom_range(1, total);
                n2    = total - n1;
            end
            thr = pick_threshold(n1, mode);
            // 32 of 64 is only affordable when the bound cuts at the root
            if (n1 == 32 && n2 == 32)
                thr = THR_MIN;
            set_config(n1, n2, thr, prune);
            for (int k = 0; k < loads; k++)
            begin
                if (n1 + n2 > MAX_VALUES_DEF || n1 + n2 == 0)
                    send_word(draw_word(mode));
                else
                    send_load(n1 + n2, mode, prune && $urandom_range(0, 99) < 85);
                if ($urandom_range(0, 9) == 0)
                    settle();
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobed word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tally_t want;
        if (rst_n && done)
        begin
            if (pending_tallies.size() == 0)
            begin
                $error("unexpected result word: match_count %0d size_error %0b",
                       match_count, size_error);
                failures++;
            end
            else
            begin
                want = pending_tallies.pop_front();
                if (match_count !== want.count)
                begin
                    $error("match_count: expected %0d, got %0d", want.count, match_count);
                    failures++;
                end
                if (size_error !== want.size_err)
                begin
                    $error("size_error: expected %0b, got %0b", want.size_err, size_error);
                    failures++;
                end
            end
        end
    end

    // Watchdog: any handshake or result resets the count of quiet cycles.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        sample_value <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_GROUP1;
        cfg_data     <= '0;
        mir_group1    = 6'd1;
        mir_group2    = 6'd1;
        mir_threshold = '0;
        mir_pruning   = 1'b1;
        words_loaded  = 0;
        words_sent    = 0;
        failures      = 0;
        steady        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_size_error();
        test_empty_total();
        test_no_picks();
        test_mid_load_resize();
        test_unsorted_pruning();
        test_random_loads();

        settle();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### subset_sum_threshold_counter.f
design/sstc_pkg.sv
design/sstc_ctrl.sv
design/sstc_datapath.sv
design/subset_sum_threshold_counter.sv
tb/tb_top.sv
